/* sv/sgag_pkg.sv */
// Shared types and constants for the strided gather address generator.
package sgag_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int SIZE_W       = 16;
    localparam int STRIDE_W     = 24;
    localparam int INDEX_W      = 32;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 24;
    localparam int PROD_W       = SIZE_W + STRIDE_W;

    // Register indexes: sizes first, then strides.
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_BASE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_BASE = CFG_INDEX_W'(4);

    typedef logic [SIZE_W-1:0]   t_coord;
    typedef logic [STRIDE_W-1:0] t_stride;
    typedef logic [INDEX_W-1:0]  t_index;

    // One beat travelling down the chain of cells. The coordinate vector is
    // shifted by one slot in every cell, so slot 0 is always the one the
    // current cell consumes.
    typedef struct packed {
        logic                       valid;
        t_index                     src;
        t_index                     dest;
        logic                       last;
        logic [MAX_DIMS-1:0][SIZE_W-1:0] coords;
    } t_beat;

endpackage

/* sv/sgag_odometer.sv */
// Coordinate odometer and element counter that launch each beat into the chain.
module sgag_odometer
    import sgag_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_restart,
    input  logic [MAX_DIMS-1:0][SIZE_W-1:0]  i_sizes,
    output t_beat                            o_beat
);

    t_coord [MAX_DIMS-1:0] r_coord;
    t_coord [MAX_DIMS-1:0] n_coord;
    t_index                r_count;
    t_index                n_count;

    t_coord [MAX_DIMS-1:0] eff_coord;
    logic   [MAX_DIMS-1:0] at_max;
    logic                  carry;
    logic                  all_max;
    t_index                eff_count;

    always_comb begin
        eff_count = i_restart ? '0 : r_count;
        all_max   = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            eff_coord[d] = i_restart ? '0 : r_coord[d];
            // A size of zero behaves like a size of one.
            at_max[d] = (i_sizes[d] == '0) || (eff_coord[d] >= i_sizes[d] - SIZE_W'(1));
            all_max   = all_max & at_max[d];
        end

        // Innermost dimension advances first; a wrap carries outward.
        carry   = 1'b1;
        n_coord = eff_coord;
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            if (carry) begin
                if (at_max[d]) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = eff_coord[d] + SIZE_W'(1);
                    carry      = 1'b0;
                end
            end
        end

        n_count = all_max ? '0 : eff_count + INDEX_W'(1);

        o_beat.valid  = i_accept;
        o_beat.src    = '0;
        o_beat.dest   = eff_count;
        o_beat.last   = all_max;
        o_beat.coords = eff_coord;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_coord <= n_coord;
            r_count <= n_count;
        end
    end

endmodule

/* sv/sgag_cell.sv */
// One cell of the chain: adds its dimension's coordinate times stride to the sum.
module sgag_cell
    import sgag_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_stride i_stride,
    input  t_beat   i_beat,
    output t_beat   o_beat
);

    t_beat               r_beat;
    t_beat               n_beat;
    logic [PROD_W-1:0]   product;

    always_comb begin
        product      = PROD_W'(i_beat.coords[0]) * PROD_W'(i_stride);
        n_beat       = i_beat;
        n_beat.src   = i_beat.src + product[INDEX_W-1:0];
        // The next dimension moves into slot 0; the top slot fills with zero.
        n_beat.coords = i_beat.coords >> SIZE_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_en) begin
            r_beat.src    <= n_beat.src;
            r_beat.dest   <= n_beat.dest;
            r_beat.last   <= n_beat.last;
            r_beat.coords <= n_beat.coords;
        end
    end

    assign o_beat = r_beat;

endmodule

/* sv/strided_gather_address_generator_top.sv */
// Top level of the strided gather address generator.
//
// The block walks a tensor of up to four dimensions in row-major order and
// emits, for every input beat, the strided source element index, the
// contiguous destination index and a flag on the final element.
// Input channel: i_valid / o_ready with the restart bit; a set restart
// clears the coordinates and the element counter before that element.
// Output channel: o_valid / i_ready with source index, dest index and last.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index in the
// same cycle. Indexes 0 to 3 are the sizes, 4 to 7 the strides; others are
// ignored. Write only while no beat is in flight.
// Throughput is one beat per cycle while the receiver does not stall. The
// odometer updates its coordinates once per accepted beat, and the products
// are summed by a chain of MAX_DIMS cells, one multiply-add per cell; each
// cell registers the beat, and o_valid comes from the last cell's register.
// When the receiver stalls, the whole chain holds and o_ready drops until
// the output beat is taken; empty slots in the chain hold as well.
// Reset clears the coordinates, the counter and the chain's valid bits, and
// returns sizes to one and strides to zero.
module strided_gather_address_generator_top
    import sgag_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_restart,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [INDEX_W-1:0]     o_source_index,
    output logic [INDEX_W-1:0]     o_dest_index,
    output logic                   o_last,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [MAX_DIMS-1:0][SIZE_W-1:0]   r_size;
    logic [MAX_DIMS-1:0][STRIDE_W-1:0] r_stride;

    logic  en;
    logic  accept;
    t_beat chain [MAX_DIMS+1];

    // Configuration registers. Slots above MAX_DIMS are simply not kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_size[d]   <= SIZE_W'(1);
                r_stride[d] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (i_cfg_index == REG_SIZE_BASE + CFG_INDEX_W'(d)) begin
                    r_size[d] <= i_cfg_data[SIZE_W-1:0];
                end
                if (i_cfg_index == REG_STRIDE_BASE + CFG_INDEX_W'(d)) begin
                    r_stride[d] <= i_cfg_data[STRIDE_W-1:0];
                end
            end
        end
    end

    // The chain moves whenever the output slot is free or being emptied.
    assign en      = !chain[MAX_DIMS].valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;

    sgag_odometer u_odometer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_restart (i_restart),
        .i_sizes   (r_size),
        .o_beat    (chain[0])
    );

    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
        sgag_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_stride (r_stride[g]),
            .i_beat   (chain[g]),
            .o_beat   (chain[g+1])
        );
    end

    assign o_valid        = chain[MAX_DIMS].valid;
    assign o_source_index = chain[MAX_DIMS].src;
    assign o_dest_index   = chain[MAX_DIMS].dest;
    assign o_last         = chain[MAX_DIMS].last;

endmodule

/* sv/sgag_checker.sv */
// Port-level assertions for the strided gather address generator.
module sgag_checker
    import sgag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [INDEX_W-1:0] o_source_index,
    input  logic [INDEX_W-1:0] o_dest_index,
    input  logic               o_last
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_source_index)
            && $stable(o_dest_index) && $stable(o_last)))
        else $error("output beat changed while stalled");

    // The chain holds as a whole, so no new beat enters during a stall.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while output stalled");

    // A free output slot always lets a beat in.
    a_free_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input blocked with free output");

    // Reset empties the chain.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind strided_gather_address_generator_top sgag_checker u_sgag_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_source_index (o_source_index),
    .o_dest_index   (o_dest_index),
    .o_last         (o_last)
);
